[rtl/kens_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the Kepler equation Newton solver.
// No dependencies; imported by the controller, datapath and top level.
package kens_pkg;

   // Q.32 angle / residual word, CORDIC x-y word (signed Q3.30), divisor word
   localparam int A32_W       = 40;
   localparam int XY_W        = 34;
   localparam int DEN_W       = 34;
   localparam int ECC_W       = 32;
   localparam int ITER_W      = 8;
   localparam int TOL_W       = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int STEP_IDX_W  = 6;
   localparam int CORDIC_STEPS = 32;

   localparam logic signed [A32_W-1:0] ONE_Q32     = 40'sh100000000;
   localparam logic signed [A32_W-1:0] PI_Q32      = 40'sh3243F6A89;
   localparam logic signed [A32_W-1:0] HALF_PI_Q32 = 40'sh1921FB544;
   localparam logic signed [A32_W-1:0] TWO_PI_Q32  = 40'sh6487ED511;
   localparam logic signed [XY_W-1:0]  CORDIC_GAIN_Q30 = 34'sh026DD3B6A;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ITERATION_LIMIT    = 2'd0,
      CSR_RELATIVE_TOLERANCE = 2'd1
   } kens_csr_type;

   typedef struct packed {
      logic                  load;
      logic                  start;
      logic                  reduce;
      logic                  fold;
      logic                  cordic;
      logic                  mul_sin;
      logic                  mul_cos;
      logic                  resid;
      logic                  div_init;
      logic                  div_step;
      logic                  update;
      logic                  test_mul;
      logic                  advance;
      logic                  out_load;
      logic [STEP_IDX_W-1:0] step_idx;
   } kens_cmd_type;

   typedef struct packed {
      logic in_range;
      logic clamp;
      logic pass;
   } kens_status_type;

   // atan(2^-i) in Q.32, rounded
   function automatic logic [A32_W-1:0] atan_q32(input logic [4:0] idx);
      logic [A32_W-1:0] val;
      case (idx)
         5'd0:    val = 40'hC90FDAA2;
         5'd1:    val = 40'h76B19C16;
         5'd2:    val = 40'h3EB6EBF2;
         5'd3:    val = 40'h1FD5BA9B;
         5'd4:    val = 40'h0FFAADDC;
         5'd5:    val = 40'h07FF556F;
         5'd6:    val = 40'h03FFEAAB;
         5'd7:    val = 40'h01FFFD55;
         5'd8:    val = 40'h00FFFFAB;
         5'd9:    val = 40'h007FFFF5;
         5'd10:   val = 40'h003FFFFF;
         default: val = A32_W'(64'd1 << (6'd32 - {1'b0, idx}));
      endcase
      return val;
   endfunction

endpackage

[rtl/kens_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer for the Newton solver: iteration, CORDIC and divider step counts.
// Depends on kens_pkg; drives kens_datapath through kens_cmd_type.
module kens_ctrl
   import kens_pkg::*;
#(
   parameter int ANGLE_WIDTH    = 32,
   parameter int MAX_ITERATIONS = 200
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [ITER_W-1:0]     iteration_limit,
   input  logic                  out_free,
   input  kens_status_type       status,
   output kens_cmd_type          cmd,
   output logic [ITER_W-1:0]     iter_count,
   output logic                  conv_flag
);

   localparam int DIV_STEPS = ANGLE_WIDTH + 2;

   typedef enum logic [13:0] {
      S_IDLE     = 14'h0001,
      S_START    = 14'h0002,
      S_REDUCE   = 14'h0004,
      S_FOLD     = 14'h0008,
      S_CORDIC   = 14'h0010,
      S_MUL_S    = 14'h0020,
      S_MUL_C    = 14'h0040,
      S_RESID    = 14'h0080,
      S_DIV_INIT = 14'h0100,
      S_DIV      = 14'h0200,
      S_UPDATE   = 14'h0400,
      S_TEST_MUL = 14'h0800,
      S_TEST     = 14'h1000,
      S_FINISH   = 14'h2000
   } kens_state_type;

   kens_state_type        state_ff, state_in;
   logic [STEP_IDX_W-1:0] cnt_ff, cnt_in;
   logic [ITER_W-1:0]     iter_ff, iter_in;
   logic                  conv_ff, conv_in;
   logic [ITER_W-1:0]     lim;

   always_comb begin
      if (iteration_limit == '0) begin
         lim = ITER_W'(1);
      end else if (iteration_limit > ITER_W'(MAX_ITERATIONS)) begin
         lim = ITER_W'(MAX_ITERATIONS);
      end else begin
         lim = iteration_limit;
      end
   end

   always_comb begin
      cmd       = '0;
      cmd.step_idx = cnt_ff;
      req_ready = 1'b0;
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      iter_in   = iter_ff;
      conv_in   = conv_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               iter_in  = ITER_W'(1);
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.start = 1'b1;
            state_in  = S_REDUCE;
         end
         S_REDUCE: begin
            cmd.reduce = 1'b1;
            if (status.in_range) state_in = S_FOLD;
         end
         S_FOLD: begin
            cmd.fold = 1'b1;
            cnt_in   = '0;
            state_in = S_CORDIC;
         end
         S_CORDIC: begin
            cmd.cordic = 1'b1;
            cnt_in     = cnt_ff + STEP_IDX_W'(1);
            if (cnt_ff == STEP_IDX_W'(CORDIC_STEPS - 1)) state_in = S_MUL_S;
         end
         S_MUL_S: begin
            cmd.mul_sin = 1'b1;
            state_in    = S_MUL_C;
         end
         S_MUL_C: begin
            cmd.mul_cos = 1'b1;
            state_in    = S_RESID;
         end
         S_RESID: begin
            cmd.resid = 1'b1;
            state_in  = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            // huge step: skip the long division, the datapath uses the clamp
            if (status.clamp) begin
               state_in = S_UPDATE;
            end else begin
               cmd.div_step = 1'b1;
               cnt_in       = cnt_ff + STEP_IDX_W'(1);
               if (cnt_ff == STEP_IDX_W'(DIV_STEPS - 1)) state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_TEST_MUL;
         end
         S_TEST_MUL: begin
            cmd.test_mul = 1'b1;
            state_in     = S_TEST;
         end
         S_TEST: begin
            if (status.pass) begin
               conv_in  = 1'b1;
               state_in = S_FINISH;
            end else if (iter_ff >= lim) begin
               conv_in  = 1'b0;
               state_in = S_FINISH;
            end else begin
               cmd.advance = 1'b1;
               iter_in     = iter_ff + ITER_W'(1);
               state_in    = S_START;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         iter_ff  <= ITER_W'(1);
         conv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         iter_ff  <= iter_in;
         conv_ff  <= conv_in;
      end
   end

   assign iter_count = iter_ff;
   assign conv_flag  = conv_ff;

   a_cordic_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CORDIC) |-> (cnt_ff < STEP_IDX_W'(CORDIC_STEPS)))
      else $error("CORDIC step count out of range");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_START && iter_ff == ITER_W'(1)))
      else $error("accepted request did not start iteration one");

   a_out_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("result loaded into a full output register");

   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (iter_ff <= lim && iter_ff != '0))
      else $error("iteration count beyond limit");

   a_iter_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TEST && !status.pass && iter_ff < lim) |=>
      (state_ff == S_START && iter_ff == $past(iter_ff) + ITER_W'(1)))
      else $error("iteration did not advance");

endmodule

[rtl/kens_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the Newton solver: CORDIC sin/cos, e*sin/e*cos, residual,
// restoring divider, estimate update and relative-step test. Uses kens_pkg.
module kens_datapath
   import kens_pkg::*;
#(
   parameter int ANGLE_WIDTH = 32
) (
   input  logic                          clock,
   input  kens_cmd_type                  cmd,
   input  logic signed [ANGLE_WIDTH-1:0] req_mean_anomaly,
   input  logic [ECC_W-1:0]              req_eccentricity,
   input  logic [TOL_W-1:0]              relative_tolerance,
   output kens_status_type               status,
   output logic signed [ANGLE_WIDTH-1:0] estimate
);

   localparam int FRAC  = ANGLE_WIDTH - 4;
   localparam int LSH   = (FRAC <= 32) ? 32 - FRAC : 0;
   localparam int RSH   = (FRAC > 32) ? FRAC - 32 : 0;
   localparam int QW    = ANGLE_WIDTH + 2;
   localparam int SW    = ANGLE_WIDTH + 3;
   localparam int DW    = ANGLE_WIDTH + 4;
   localparam int NUM_W = A32_W;
   localparam int REM_W = DEN_W + 7;
   localparam int PW    = ANGLE_WIDTH + TOL_W;
   localparam int CMPW  = (PW > 63) ? PW : 63;

   function automatic logic signed [A32_W-1:0] to_q32(
      input logic signed [ANGLE_WIDTH-1:0] v);
      logic signed [ANGLE_WIDTH+32:0] ext;
      ext = (ANGLE_WIDTH+33)'(v);
      return A32_W'((ext <<< LSH) >>> RSH);
   endfunction

   // round(e * v / 2^30), half away from zero
   function automatic logic signed [A32_W-1:0] mul_e(
      input logic [ECC_W-1:0] e, input logic signed [XY_W-1:0] v);
      logic [XY_W-1:0]       mag;
      logic [XY_W+ECC_W-1:0] prod;
      logic [XY_W+1:0]       r;
      mag  = v[XY_W-1] ? XY_W'(-v) : XY_W'(v);
      prod = e * mag;
      r    = (XY_W+2)'((prod + (XY_W+ECC_W)'(64'd1 << 29)) >> 30);
      return v[XY_W-1] ? -$signed(A32_W'(r)) : $signed(A32_W'(r));
   endfunction

   logic signed [ANGLE_WIDTH-1:0] e0_ff, en_ff;
   logic signed [A32_W-1:0]       m32_ff, a_ff, z_ff, es_ff, ec_ff;
   logic [ECC_W-1:0]              ecc_ff;
   logic signed [XY_W-1:0]        x_ff, y_ff;
   logic                          neg_ff, gneg_ff, clamp_ff;
   logic [NUM_W-1:0]              num_ff;
   logic [DEN_W-1:0]              den_ff;
   logic [REM_W-1:0]              rem_ff;
   logic [QW-1:0]                 q_ff;
   logic [ANGLE_WIDTH:0]          d_ff;
   logic [ANGLE_WIDTH-1:0]        eabs_ff;
   logic [PW-1:0]                 tolp_ff;

   logic signed [XY_W-1:0]  xs, ys, cos_v, mul_src;
   logic signed [A32_W-1:0] zt, mul_res, a_new, g_v, gp_v;
   logic [REM_W-1:0]        sub_v;
   logic [SW-1:0]           smag;
   logic signed [DW-1:0]    step_v, diff_v;
   logic signed [ANGLE_WIDTH-1:0] en_v;
   logic signed [ANGLE_WIDTH:0]   dd_v;
   logic [CMPW-1:0]         lhs_v, rhs_v;

   always_comb begin
      xs      = x_ff >>> cmd.step_idx[4:0];
      ys      = y_ff >>> cmd.step_idx[4:0];
      zt      = $signed(atan_q32(cmd.step_idx[4:0]));
      cos_v   = neg_ff ? -x_ff : x_ff;
      mul_src = cmd.mul_cos ? cos_v : y_ff;
      mul_res = mul_e(ecc_ff, mul_src);
      a_new   = to_q32(e0_ff);
      g_v     = a_ff - es_ff - m32_ff;
      gp_v    = ONE_Q32 - ec_ff;
      if (gp_v < 40'sd1) gp_v = 40'sd1;
      sub_v   = REM_W'({den_ff, 5'b0});
      smag    = clamp_ff ? (SW'(1) << QW) : SW'(q_ff);
      step_v  = gneg_ff ? -$signed(DW'(smag)) : $signed(DW'(smag));
      diff_v  = DW'(e0_ff) - step_v;
      // saturate to the angle field
      if (diff_v[DW-1:ANGLE_WIDTH-1] == '0 || diff_v[DW-1:ANGLE_WIDTH-1] == '1) begin
         en_v = diff_v[ANGLE_WIDTH-1:0];
      end else if (diff_v[DW-1]) begin
         en_v = {1'b1, {(ANGLE_WIDTH-1){1'b0}}};
      end else begin
         en_v = {1'b0, {(ANGLE_WIDTH-1){1'b1}}};
      end
      dd_v  = (ANGLE_WIDTH+1)'(en_v) - (ANGLE_WIDTH+1)'(e0_ff);
      lhs_v = CMPW'({23'(d_ff), 40'b0});
      rhs_v = CMPW'(tolp_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         e0_ff  <= req_mean_anomaly;
         m32_ff <= to_q32(req_mean_anomaly);
         ecc_ff <= req_eccentricity;
      end
      if (cmd.advance) e0_ff <= en_ff;
      if (cmd.start) begin
         a_ff <= a_new;
         z_ff <= a_new;
      end
      if (cmd.reduce) begin
         if (z_ff > PI_Q32) begin
            z_ff <= z_ff - TWO_PI_Q32;
         end else if (z_ff < -PI_Q32) begin
            z_ff <= z_ff + TWO_PI_Q32;
         end
      end
      if (cmd.fold) begin
         x_ff <= CORDIC_GAIN_Q30;
         y_ff <= '0;
         if (z_ff > HALF_PI_Q32) begin
            z_ff   <= PI_Q32 - z_ff;
            neg_ff <= 1'b1;
         end else if (z_ff < -HALF_PI_Q32) begin
            z_ff   <= -PI_Q32 - z_ff;
            neg_ff <= 1'b1;
         end else begin
            neg_ff <= 1'b0;
         end
      end
      if (cmd.cordic) begin
         if (!z_ff[A32_W-1]) begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - zt;
         end else begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + zt;
         end
      end
      if (cmd.mul_sin) es_ff <= mul_res;
      if (cmd.mul_cos) ec_ff <= mul_res;
      if (cmd.resid) begin
         gneg_ff <= g_v[A32_W-1];
         num_ff  <= g_v[A32_W-1] ? NUM_W'(-g_v) : NUM_W'(g_v);
         den_ff  <= DEN_W'(gp_v);
      end
      if (cmd.div_init) begin
         clamp_ff <= REM_W'(num_ff) >= REM_W'({den_ff, 6'b0});
         rem_ff   <= REM_W'(num_ff);
         q_ff     <= '0;
      end
      if (cmd.div_step) begin
         if (rem_ff >= sub_v) begin
            rem_ff <= REM_W'((rem_ff - sub_v) << 1);
            q_ff   <= {q_ff[QW-2:0], 1'b1};
         end else begin
            rem_ff <= REM_W'(rem_ff << 1);
            q_ff   <= {q_ff[QW-2:0], 1'b0};
         end
      end
      if (cmd.update) begin
         en_ff   <= en_v;
         d_ff    <= dd_v[ANGLE_WIDTH] ? (ANGLE_WIDTH+1)'(-dd_v) : (ANGLE_WIDTH+1)'(dd_v);
         eabs_ff <= en_v[ANGLE_WIDTH-1] ? ANGLE_WIDTH'(-en_v) : ANGLE_WIDTH'(en_v);
      end
      if (cmd.test_mul) tolp_ff <= relative_tolerance * eabs_ff;
   end

   assign status.in_range = !(z_ff > PI_Q32) && !(z_ff < -PI_Q32);
   assign status.clamp    = clamp_ff;
   assign status.pass     = ((d_ff >> 23) == '0) && (lhs_v <= rhs_v);
   assign estimate        = en_ff;

endmodule

[rtl/kepler_equation_newton_solver_top.sv]
`timescale 1ns / 1ps
// Top level of the Kepler equation Newton solver: CSRs, output register,
// controller and datapath. Depends on kens_pkg, kens_ctrl, kens_datapath.
//
//  channel  ports                                            direction
//  req      req_valid/ready, mean_anomaly, eccentricity      in
//  rsp      rsp_valid/ready, eccentric_anomaly, converged,   out
//           iterations_used
//  csr      csr_valid/ready, csr_index, csr_data             in
//
// Each Newton iteration runs 32 CORDIC steps and ANGLE_WIDTH+2 restoring divider
// steps, after 2*pi reduction steps bring the angle within +-pi; a clamped step
// skips the divider steps.
// One request is in work at a time; a finished result waits in the output
// register while the next request is accepted. Synchronous reset, no clearing pass.
module kepler_equation_newton_solver_top
   import kens_pkg::*;
#(
   parameter int ANGLE_WIDTH    = 32,
   parameter int MAX_ITERATIONS = 200
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [ANGLE_WIDTH-1:0] req_mean_anomaly,
   input  logic [ECC_W-1:0]              req_eccentricity,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [ANGLE_WIDTH-1:0] rsp_eccentric_anomaly,
   output logic                          rsp_converged,
   output logic [ITER_W-1:0]             rsp_iterations_used,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [TOL_W-1:0]              csr_data
);

   kens_cmd_type                  cmd;
   kens_status_type               status;
   logic [ITER_W-1:0]             limit_ff, iter_count;
   logic [TOL_W-1:0]              tol_ff;
   logic                          rsp_valid_ff, conv_flag, out_free;
   logic signed [ANGLE_WIDTH-1:0] estimate, ea_ff;
   logic                          conv_ff;
   logic [ITER_W-1:0]             used_ff;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= ITER_W'(200);
         tol_ff   <= TOL_W'(136);
      end else if (csr_valid) begin
         if (csr_index == CSR_ITERATION_LIMIT) limit_ff <= csr_data[ITER_W-1:0];
         if (csr_index == CSR_RELATIVE_TOLERANCE) tol_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         ea_ff   <= estimate;
         conv_ff <= conv_flag;
         used_ff <= iter_count;
      end
   end

   kens_ctrl #(
      .ANGLE_WIDTH    (ANGLE_WIDTH),
      .MAX_ITERATIONS (MAX_ITERATIONS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .iteration_limit (limit_ff),
      .out_free        (out_free),
      .status          (status),
      .cmd             (cmd),
      .iter_count      (iter_count),
      .conv_flag       (conv_flag)
   );

   kens_datapath #(
      .ANGLE_WIDTH (ANGLE_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .cmd                (cmd),
      .req_mean_anomaly   (req_mean_anomaly),
      .req_eccentricity   (req_eccentricity),
      .relative_tolerance (tol_ff),
      .status             (status),
      .estimate           (estimate)
   );

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_eccentric_anomaly = ea_ff;
   assign rsp_converged         = conv_ff;
   assign rsp_iterations_used   = used_ff;

endmodule

[tb/kepler_equation_newton_solver_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for kepler_equation_newton_solver_top: directed and random
// requests with random stalls, checked against a bit-exact Newton/CORDIC predictor.
// Depends on kens_pkg and the solver RTL.
module kepler_equation_newton_solver_top_tb
   import kens_pkg::*;
;

   localparam int AW = 32;
   localparam int FRAC = AW - 4;
   localparam int MAX_ITER = 200;
   localparam longint CYCLE_LIMIT = 40000000;

   typedef struct {
      logic signed [AW-1:0] anomaly;
      logic [ECC_W-1:0]     ecc;
   } orbit_req_type;

   typedef struct {
      logic signed [AW-1:0] ecc_anomaly;
      logic                 conv;
      logic [ITER_W-1:0]    iters;
   } solution_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [AW-1:0] req_mean_anomaly = '0;
   logic [ECC_W-1:0] req_eccentricity = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [AW-1:0] rsp_eccentric_anomaly;
   logic rsp_converged;
   logic [ITER_W-1:0] rsp_iterations_used;
   logic csr_valid = 1'b0;
   logic csr_ready;
   kens_csr_type csr_index = CSR_ITERATION_LIMIT;
   logic [TOL_W-1:0] csr_data = '0;

   kepler_equation_newton_solver_top #(.ANGLE_WIDTH(AW), .MAX_ITERATIONS(MAX_ITER)) dut (
      .clock, .reset, .req_valid, .req_ready, .req_mean_anomaly, .req_eccentricity,
      .rsp_valid, .rsp_ready, .rsp_eccentric_anomaly, .rsp_converged,
      .rsp_iterations_used, .csr_valid, .csr_ready, .csr_index, .csr_data);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   orbit_req_type pending_reqs[$];
   solution_type  expected_solutions[$];
   orbit_req_type next_req;
   solution_type  got;
   int errors = 0;
   bit idling_on = 1'b1;
   int req_gap = 0;
   int rsp_gap = 0;
   longint cycles = 0;

   // shadow of the CSRs
   logic [ITER_W-1:0] iter_limit_reg = 8'd200;
   logic [TOL_W-1:0]  tol_reg = 16'd136;
   longint atan_q32[CORDIC_STEPS];

   function automatic longint sat_angle(longint v);
      longint hi, lo;
      hi = (longint'(1) <<< (AW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // round(e * v / 2^30), half away from zero
   function automatic longint ecc_scale(longint unsigned e, longint v);
      longint unsigned mag, r;
      mag = (v < 0) ? longint'(-v) : v;
      r = (e * mag + (64'd1 << 29)) >> 30;
      return (v < 0) ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint unsigned newton_quotient(longint unsigned num,
                                                       longint unsigned den);
      longint unsigned q, rem;
      q = num / den;
      rem = num % den;
      if (q >= 64) return 64'd64 << FRAC;
      for (int b = 0; b < FRAC; b++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= den) begin
            rem = rem - den;
            q = q | 1;
         end
      end
      return q;
   endfunction

   task automatic cordic_sin_cos(input longint ang, output longint s, output longint c);
      longint x, y, z, xs, ys;
      bit neg_cos;
      x = 64'sh26DD3B6A;
      y = 0;
      neg_cos = 1'b0;
      while (ang > 64'sh3243F6A89) ang -= 64'sh6487ED511;
      while (ang < -64'sh3243F6A89) ang += 64'sh6487ED511;
      if (ang > 64'sh1921FB544) begin
         ang = 64'sh3243F6A89 - ang;
         neg_cos = 1'b1;
      end else if (ang < -64'sh1921FB544) begin
         ang = -64'sh3243F6A89 - ang;
         neg_cos = 1'b1;
      end
      z = ang;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= atan_q32[i];
         end else begin
            x += ys; y -= xs; z += atan_q32[i];
         end
      end
      s = y;
      c = neg_cos ? -x : x;
   endtask

   task automatic solve_kepler(input orbit_req_type r, output solution_type sol);
      longint m, m32, e0, en, a, sv, cv, g, gp, step;
      longint unsigned e, mag, q, d, eabs, lim;
      bit conv;
      lim = iter_limit_reg;
      if (lim < 1) lim = 1;
      if (lim > MAX_ITER) lim = MAX_ITER;
      m = longint'(r.anomaly);
      e = r.ecc;
      m32 = m * 16;
      e0 = m;
      en = m;
      conv = 1'b0;
      sol.iters = lim[ITER_W-1:0];
      for (longint it = 1; it <= lim; it++) begin
         a = e0 * 16;
         cordic_sin_cos(a, sv, cv);
         g = a - ecc_scale(e, sv) - m32;
         gp = 64'sh100000000 - ecc_scale(e, cv);
         if (gp < 1) gp = 1;
         mag = (g < 0) ? longint'(-g) : g;
         q = newton_quotient(mag, gp);
         step = (g < 0) ? -longint'(q) : longint'(q);
         en = sat_angle(e0 - step);
         d = (en >= e0) ? en - e0 : e0 - en;
         eabs = (en < 0) ? -en : en;
         if (d < (64'd1 << 23) && (d << 40) <= longint'(tol_reg) * eabs) begin
            conv = 1'b1;
            sol.iters = it[ITER_W-1:0];
            break;
         end
         e0 = en;
      end
      sol.ecc_anomaly = en[AW-1:0];
      sol.conv = conv;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_valid && req_ready) begin
            solution_type sol;
            solve_kepler('{req_mean_anomaly, req_eccentricity}, sol);
            expected_solutions.push_back(sol);
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_valid <= 1'b0;
               req_gap <= req_gap - 1;
            end else if (pending_reqs.size() > 0) begin
               next_req = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_mean_anomaly <= next_req.anomaly;
               req_eccentricity <= next_req.ecc;
               if (idling_on && $urandom_range(0, 3) == 0) req_gap <= $urandom_range(1, 12);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_solutions.size() == 0) begin
               $display("%0t: unexpected result E=%h conv=%b iters=%0d", $time,
                        rsp_eccentric_anomaly, rsp_converged, rsp_iterations_used);
               errors++;
            end else begin
               got = expected_solutions.pop_front();
               if (rsp_eccentric_anomaly !== got.ecc_anomaly) begin
                  $display("%0t: eccentric_anomaly expected %h actual %h", $time,
                           got.ecc_anomaly, rsp_eccentric_anomaly);
                  errors++;
               end
               if (rsp_converged !== got.conv) begin
                  $display("%0t: converged expected %b actual %b", $time,
                           got.conv, rsp_converged);
                  errors++;
               end
               if (rsp_iterations_used !== got.iters) begin
                  $display("%0t: iterations_used expected %0d actual %0d", $time,
                           got.iters, rsp_iterations_used);
                  errors++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_ready <= 1'b0;
            rsp_gap <= rsp_gap - 1;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            rsp_gap <= $urandom_range(0, 11);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic write_csr(input kens_csr_type idx, input logic [TOL_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_ITERATION_LIMIT) iter_limit_reg = val[ITER_W-1:0];
      else tol_reg = val;
   endtask

   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (pending_reqs.size() > 0 || req_valid || expected_solutions.size() > 0);
      repeat (100) @(posedge clock);
   endtask

   function automatic logic [ECC_W-1:0] rand_ecc();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 32'h3FFFFFFF);
         2: return 32'hFFFFFFFF - $urandom_range(0, 32'h00FFFFFF);
         default: return $urandom_range(32'h40000000, 32'hE0000000);
      endcase
   endfunction

   task automatic queue_random(input int n);
      orbit_req_type r;
      for (int i = 0; i < n; i++) begin
         r.anomaly = ($urandom_range(0, 3) == 0) ? $urandom
                     : $signed($urandom_range(0, 32'h7FFFFFFF)) >>> $urandom_range(0, 6);
         if ($urandom_range(0, 1)) r.anomaly = -r.anomaly;
         r.ecc = rand_ecc();
         pending_reqs.push_back(r);
      end
   endtask

   initial begin
      longint unsigned v;
      atan_q32[0] = 64'hC90FDAA2;
      for (int i = 1; i < CORDIC_STEPS; i++) begin
         v = 0;
         for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
            if (k % 2) v -= (64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1);
            else v += (64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1);
         end
         atan_q32[i] = (v + (64'd1 << 29)) >> 30;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, zero estimate, pi, derivative near zero, huge steps
      pending_reqs.push_back('{32'sd0, 32'd0});
      pending_reqs.push_back('{32'sd0, 32'hFFFFFFFF});
      pending_reqs.push_back('{32'sh7FFFFFFF, 32'd0});
      pending_reqs.push_back('{32'sh80000000, 32'd0});
      pending_reqs.push_back('{32'sh7FFFFFFF, 32'hFFFFFFFF});
      pending_reqs.push_back('{32'sh80000000, 32'hFFFFFFFF});
      pending_reqs.push_back('{32'sh3243F6A9, 32'h80000000});
      pending_reqs.push_back('{-32'sh3243F6A9, 32'hF0000000});
      pending_reqs.push_back('{32'sd1, 32'hFFFFFFFF});
      pending_reqs.push_back('{-32'sd1, 32'hFFFFFFFF});
      pending_reqs.push_back('{32'sh00100000, 32'hFFFF0000});
      pending_reqs.push_back('{32'sh1921FB54, 32'h55555555});
      pending_reqs.push_back('{32'sh6487ED51, 32'hAAAAAAAA});
      pending_reqs.push_back('{32'sh10000000, 32'h00000001});
      wait_drained();

      // one iteration only, exact-step convergence
      write_csr(CSR_ITERATION_LIMIT, 16'd0);
      write_csr(CSR_RELATIVE_TOLERANCE, 16'd0);
      pending_reqs.push_back('{32'sd0, 32'hFFFFFFFF});
      pending_reqs.push_back('{32'sh7FFFFFFF, 32'hFFFFFFFF});
      queue_random(120);
      wait_drained();

      // above the limit acts as the maximum; loosest tolerance
      write_csr(CSR_ITERATION_LIMIT, 16'd255);
      write_csr(CSR_RELATIVE_TOLERANCE, 16'd65535);
      queue_random(150);
      wait_drained();

      write_csr(CSR_ITERATION_LIMIT, 16'd12);
      write_csr(CSR_RELATIVE_TOLERANCE, 16'd0);
      queue_random(120);
      wait_drained();

      write_csr(CSR_ITERATION_LIMIT, 16'd1);
      write_csr(CSR_RELATIVE_TOLERANCE, 16'd136);
      queue_random(100);
      wait_drained();

      write_csr(CSR_ITERATION_LIMIT, 16'd200);
      queue_random(120);
      wait_drained();

      for (int p = 0; p < 3; p++) begin
         write_csr(CSR_ITERATION_LIMIT, $urandom_range(2, 30));
         write_csr(CSR_RELATIVE_TOLERANCE, $urandom_range(0, 65535));
         queue_random(70);
         wait_drained();
      end

      // closing stretch at full rate
      idling_on = 1'b0;
      write_csr(CSR_ITERATION_LIMIT, 16'd40);
      write_csr(CSR_RELATIVE_TOLERANCE, 16'd136);
      queue_random(40);
      wait_drained();

      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
